// ===== hw/rtl/dhr_pkg.sv =====
// ----------------------------------------------------------------------------
// dhr_pkg
// Shared types and constants for the staged dehumidifier rotation controller.
// ----------------------------------------------------------------------------
`default_nettype none

package dhr_pkg;

    localparam int CFG_ADDR_BITS    = 5;
    localparam int CFG_DATA_BITS    = 32;
    localparam int CMP_BITS         = 32;
    localparam int COUNTER_BITS_DEF = 16;
    localparam int NUM_UNITS        = 3;

    localparam logic [15:0] MAX_RUN_RST   = 16'd600;
    localparam logic [15:0] MIN_OFF_RST   = 16'd60;
    localparam logic [15:0] MIN_ON_RST    = 16'd120;
    localparam logic [6:0]  HUM_ONE_RST   = 7'd50;
    localparam logic [6:0]  HUM_TWO_RST   = 7'd60;
    localparam logic [6:0]  HUM_THREE_RST = 7'd70;

    localparam logic [1:0] UNIT_SEL_NONE = 2'd3;

    typedef enum logic [2:0] {
        ACT_TICK         = 3'd0,
        ACT_SET_HUM      = 3'd1,
        ACT_TOGGLE_UNIT  = 3'd2,
        ACT_TOGGLE_AUTO  = 3'd3,
        ACT_TOGGLE_POWER = 3'd4,
        ACT_EVAL         = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        REG_MAX_RUN   = 3'd0,
        REG_MIN_OFF   = 3'd1,
        REG_MIN_ON    = 3'd2,
        REG_HUM_ONE   = 3'd3,
        REG_HUM_TWO   = 3'd4,
        REG_HUM_THREE = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] max_run;
        logic [15:0] min_off;
        logic [15:0] min_on;
        logic [6:0]  hum_one;
        logic [6:0]  hum_two;
        logic [6:0]  hum_three;
    } t_cfg;

    typedef struct packed {
        logic [2:0] action;
        logic [6:0] humidity;
        logic [1:0] unit_select;
    } t_item;

    typedef struct packed {
        logic [NUM_UNITS-1:0] unit_on;
        logic                 power_on;
        logic                 auto_mode;
    } t_status;

endpackage

`default_nettype wire

// ===== hw/rtl/dhr_in_if.sv =====
// ----------------------------------------------------------------------------
// dhr_in_if
// Command channel: one word per tick, humidity update, toggle or evaluate.
// ----------------------------------------------------------------------------
`default_nettype none

interface dhr_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [6:0] humidity;
    logic [1:0] unit_select;

    modport source (output valid, output action, output humidity, output unit_select,
                    input ready);
    modport sink   (input valid, input action, input humidity, input unit_select,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dhr_out_if.sv =====
// ----------------------------------------------------------------------------
// dhr_out_if
// Status channel: relay and mode states after each command word.
// ----------------------------------------------------------------------------
`default_nettype none

interface dhr_out_if;
    logic valid;
    logic ready;
    logic dryer_a_on;
    logic dryer_b_on;
    logic dryer_c_on;
    logic system_power_on;
    logic auto_mode;

    modport source (output valid, output dryer_a_on, output dryer_b_on, output dryer_c_on,
                    output system_power_on, output auto_mode, input ready);
    modport sink   (input valid, input dryer_a_on, input dryer_b_on, input dryer_c_on,
                    input system_power_on, input auto_mode, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dhr_regs.sv =====
// ----------------------------------------------------------------------------
// dhr_regs
// APB configuration registers: run and rest limits and humidity thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module dhr_regs
    import dhr_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [CFG_DATA_BITS-1:0] pwdata,
    output logic      [CFG_DATA_BITS-1:0] prdata,
    output logic                          pready,
    output t_cfg                          o_cfg
);

    t_cfg       r_cfg;
    logic [2:0] idx;
    logic       wr_en;

    assign idx    = paddr[CFG_ADDR_BITS-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_run   <= MAX_RUN_RST;
            r_cfg.min_off   <= MIN_OFF_RST;
            r_cfg.min_on    <= MIN_ON_RST;
            r_cfg.hum_one   <= HUM_ONE_RST;
            r_cfg.hum_two   <= HUM_TWO_RST;
            r_cfg.hum_three <= HUM_THREE_RST;
        end else if (wr_en) begin
            unique case (idx)
                REG_MAX_RUN:   r_cfg.max_run   <= pwdata[15:0];
                REG_MIN_OFF:   r_cfg.min_off   <= pwdata[15:0];
                REG_MIN_ON:    r_cfg.min_on    <= pwdata[15:0];
                REG_HUM_ONE:   r_cfg.hum_one   <= pwdata[6:0];
                REG_HUM_TWO:   r_cfg.hum_two   <= pwdata[6:0];
                REG_HUM_THREE: r_cfg.hum_three <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_MAX_RUN:   prdata = CFG_DATA_BITS'(r_cfg.max_run);
            REG_MIN_OFF:   prdata = CFG_DATA_BITS'(r_cfg.min_off);
            REG_MIN_ON:    prdata = CFG_DATA_BITS'(r_cfg.min_on);
            REG_HUM_ONE:   prdata = CFG_DATA_BITS'(r_cfg.hum_one);
            REG_HUM_TWO:   prdata = CFG_DATA_BITS'(r_cfg.hum_two);
            REG_HUM_THREE: prdata = CFG_DATA_BITS'(r_cfg.hum_three);
            default:       prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dhr_core.sv =====
// ----------------------------------------------------------------------------
// dhr_core
// Unit state, elapsed counters and the staging decision for one command word.
// ----------------------------------------------------------------------------
`default_nettype none

module dhr_core
    import dhr_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_fire,
    input  wire t_item i_item,
    output t_status    o_next
);

    localparam logic [COUNTER_BITS-1:0] CNT_RST = COUNTER_BITS'(MIN_OFF_RST);

    logic [COUNTER_BITS-1:0] r_cnt [NUM_UNITS];
    logic [COUNTER_BITS-1:0] n_cnt [NUM_UNITS];
    logic [NUM_UNITS-1:0]    r_on, n_on;
    logic                    r_pwr, n_pwr;
    logic                    r_auto, n_auto;
    logic [6:0]              r_hum, n_hum;

    function automatic logic above(input logic [COUNTER_BITS-1:0] c, input logic [15:0] lim);
        return CMP_BITS'(c) > CMP_BITS'(lim);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int u = 0; u < NUM_UNITS; u++) begin
                r_cnt[u] <= CNT_RST;
            end
            r_on   <= '0;
            r_pwr  <= 1'b0;
            r_auto <= 1'b1;
            r_hum  <= '0;
        end else begin
            for (int u = 0; u < NUM_UNITS; u++) begin
                r_cnt[u] <= n_cnt[u];
            end
            r_on   <= n_on;
            r_pwr  <= n_pwr;
            r_auto <= n_auto;
            r_hum  <= n_hum;
        end
    end

    always_comb begin
        logic [1:0] top;
        logic [1:0] mid;
        logic [1:0] cnt_on;
        n_cnt  = r_cnt;
        n_on   = r_on;
        n_pwr  = r_pwr;
        n_auto = r_auto;
        n_hum  = r_hum;
        top    = 2'd0;
        mid    = 2'd0;
        cnt_on = 2'd0;
        // order units by elapsed count, strict compares
        if (r_cnt[0] < r_cnt[1]) begin
            if (r_cnt[1] < r_cnt[2]) begin
                mid = 2'd1; top = 2'd2;
            end else if (r_cnt[0] < r_cnt[2]) begin
                mid = 2'd2; top = 2'd1;
            end else begin
                mid = 2'd0; top = 2'd1;
            end
        end else begin
            if (r_cnt[0] < r_cnt[2]) begin
                mid = 2'd0; top = 2'd2;
            end else if (r_cnt[2] < r_cnt[1]) begin
                mid = 2'd1; top = 2'd0;
            end else begin
                mid = 2'd2; top = 2'd0;
            end
        end
        if (i_fire) begin
            case (i_item.action)
                ACT_TICK: begin
                    for (int u = 0; u < NUM_UNITS; u++) begin
                        if (r_cnt[u] != '1) begin
                            n_cnt[u] = r_cnt[u] + 1'b1;
                        end
                    end
                end
                ACT_SET_HUM: n_hum = i_item.humidity;
                ACT_TOGGLE_UNIT: begin
                    if (i_item.unit_select != UNIT_SEL_NONE) begin
                        n_auto                     = 1'b0;
                        n_on[i_item.unit_select]   = !r_on[i_item.unit_select];
                        n_cnt[i_item.unit_select]  = '0;
                    end
                end
                ACT_TOGGLE_AUTO:  n_auto = !r_auto;
                ACT_TOGGLE_POWER: n_pwr  = !r_pwr;
                ACT_EVAL: begin
                    if (r_auto) begin
                        // forced off past max run
                        for (int u = 0; u < NUM_UNITS; u++) begin
                            if (n_on[u] && above(n_cnt[u], i_cfg.max_run)) begin
                                n_on[u]  = 1'b0;
                                n_cnt[u] = '0;
                            end
                        end
                        cnt_on = 2'(n_on[0]) + 2'(n_on[1]) + 2'(n_on[2]);
                        if (r_hum >= i_cfg.hum_three) begin
                            for (int u = 0; u < NUM_UNITS; u++) begin
                                if (!n_on[u] && above(n_cnt[u], i_cfg.min_off)) begin
                                    n_on[u] = 1'b1; n_cnt[u] = '0;
                                end
                            end
                        end else if (r_hum >= i_cfg.hum_two) begin
                            if (cnt_on == 2'd0) begin
                                if (!n_on[top] && above(n_cnt[top], i_cfg.min_off)) begin
                                    n_on[top] = 1'b1; n_cnt[top] = '0;
                                end
                                if (!n_on[mid] && above(n_cnt[mid], i_cfg.min_off)) begin
                                    n_on[mid] = 1'b1; n_cnt[mid] = '0;
                                end
                            end else if (cnt_on == 2'd1) begin
                                if (!n_on[top] && above(n_cnt[top], i_cfg.min_off)) begin
                                    n_on[top] = 1'b1; n_cnt[top] = '0;
                                end else if (!n_on[mid] && above(n_cnt[mid], i_cfg.min_off))
                                begin
                                    n_on[mid] = 1'b1; n_cnt[mid] = '0;
                                end
                            end else if (cnt_on == 2'd3) begin
                                if (n_on[top] && above(n_cnt[top], i_cfg.min_on)) begin
                                    n_on[top] = 1'b0; n_cnt[top] = '0;
                                end
                            end
                        end else if (r_hum >= i_cfg.hum_one) begin
                            if (cnt_on == 2'd0) begin
                                if (!n_on[top] && above(n_cnt[top], i_cfg.min_off)) begin
                                    n_on[top] = 1'b1; n_cnt[top] = '0;
                                end
                            end else if (cnt_on == 2'd2) begin
                                if (n_on[top] && above(n_cnt[top], i_cfg.min_on)) begin
                                    n_on[top] = 1'b0; n_cnt[top] = '0;
                                end else if (n_on[mid] && above(n_cnt[mid], i_cfg.min_on))
                                begin
                                    n_on[mid] = 1'b0; n_cnt[mid] = '0;
                                end
                            end else if (cnt_on == 2'd3) begin
                                if (n_on[top] && above(n_cnt[top], i_cfg.min_on)) begin
                                    n_on[top] = 1'b0; n_cnt[top] = '0;
                                end
                                if (n_on[mid] && above(n_cnt[mid], i_cfg.min_on)) begin
                                    n_on[mid] = 1'b0; n_cnt[mid] = '0;
                                end
                            end
                        end else begin
                            for (int u = 0; u < NUM_UNITS; u++) begin
                                if (n_on[u] && above(n_cnt[u], i_cfg.min_on)) begin
                                    n_on[u] = 1'b0; n_cnt[u] = '0;
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_next = '{unit_on: n_on, power_on: n_pwr, auto_mode: n_auto};

endmodule

`default_nettype wire

// ===== hw/rtl/staged_dehumidifier_rotation.sv =====
// ----------------------------------------------------------------------------
// staged_dehumidifier_rotation
// Stages three dehumidifier relays from a stored humidity reading.
//
// Command words enter on i_in (tick, set humidity, toggle unit, toggle auto,
// toggle power, evaluate). Every accepted word yields exactly one status word
// on o_out: the three relay states, the power relay and the auto mode flag as
// they stand after the command.
// A word is registered at acceptance and processed when the output register
// is free or its word is being taken; that edge loads the output register.
// With o_out not stalling, one word per cycle is sustained; the decision for a
// word is a single pass over the three counters between the two registers.
// When o_out stalls, the output register holds and one more command waits in
// the input register; ready then drops until the status word is taken.
// Reset clears both valid flags, turns all relays and power off, enables auto
// mode, clears the humidity and loads the counters with the min off reset.
// Thresholds and limits are to be written over APB only while the block idles;
// the block itself does not enforce this.
`default_nettype none

module staged_dehumidifier_rotation
    import dhr_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    dhr_in_if.sink                        i_in,
    dhr_out_if.source                     o_out,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [CFG_DATA_BITS-1:0] pwdata,
    output logic      [CFG_DATA_BITS-1:0] prdata,
    output logic                          pready
);

    t_cfg    cfg;
    t_item   r_in;
    logic    r_in_valid;
    t_status r_res;
    logic    r_res_valid;
    t_status next_status;
    logic    fire;

    assign fire       = r_in_valid && (!r_res_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || fire;

    dhr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dhr_core #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_fire  (fire),
        .i_item  (r_in),
        .o_next  (next_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= '{action: i_in.action, humidity: i_in.humidity,
                      unit_select: i_in.unit_select};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (fire) begin
            r_res_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= next_status;
        end
    end

    assign o_out.valid           = r_res_valid;
    assign o_out.dryer_a_on      = r_res.unit_on[0];
    assign o_out.dryer_b_on      = r_res.unit_on[1];
    assign o_out.dryer_c_on      = r_res.unit_on[2];
    assign o_out.system_power_on = r_res.power_on;
    assign o_out.auto_mode       = r_res.auto_mode;

`ifndef SYNTHESIS
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_in_valid)
        else $error("accepted word not held in input register");

    a_hold_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !fire |=> r_in_valid && $stable(r_in))
        else $error("pending word lost or changed");

    a_manual_clears_auto: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_in.action == ACT_TOGGLE_UNIT && r_in.unit_select != UNIT_SEL_NONE
        |=> !o_out.auto_mode && o_out.valid)
        else $error("manual toggle did not leave auto mode");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_staged_dehumidifier_rotation.sv =====
// ----------------------------------------------------------------------------
// tb_staged_dehumidifier_rotation
// Self-checking bench for the staged dehumidifier controller. Command words
// are fed from a queue with random sender gaps. An in-bench model of the
// relay staging predicts one status word per command. Status words are taken
// with random receiver stalls and compared field by field. Limits and
// humidity bands are rewritten and read back over APB between phases while
// the block is idle. One long tick stretch runs the counters past the run
// limit.
// ----------------------------------------------------------------------------
module tb_staged_dehumidifier_rotation;
    timeunit 1ns;
    timeprecision 1ps;

    import dhr_pkg::*;

    localparam int CNT_W = COUNTER_BITS_DEF;
    localparam logic [CNT_W-1:0] CNT_TOP = '1;
    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;
    localparam logic [1:0] UNIT_A = 2'd0;
    localparam logic [1:0] UNIT_B = 2'd1;
    localparam logic [1:0] UNIT_C = 2'd2;
    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_TICKS = 100;
    localparam int RAND_PER_SET = 150;
    localparam int MAX_SHOWN = 40;

    typedef struct {
        t_status     st;
        int unsigned seq;
    } t_pending;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [CFG_ADDR_BITS-1:0] paddr;
    logic [CFG_DATA_BITS-1:0] pwdata;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;

    dhr_in_if  cmd_if ();
    dhr_out_if stat_if ();

    staged_dehumidifier_rotation #(
        .COUNTER_BITS (CNT_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (stat_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // model state
    t_cfg                 cfg_now;
    logic [CNT_W-1:0]     run_cnt [NUM_UNITS];
    logic [NUM_UNITS-1:0] relay;
    logic                 pwr_on;
    logic                 auto_on;
    logic [6:0]           hum_now;

    t_item       cmd_q [$];
    t_pending    status_q [$];
    int          src_idle_pct;
    int          snk_stall_pct;
    int          errors;
    int          quiet;
    int unsigned seq_in;
    bit          plan_auto;
    string       field_name [5] = '{"auto_mode", "system_power_on", "dryer_a_on",
                                    "dryer_b_on", "dryer_c_on"};

    task automatic report_bad(string msg);
        errors++;
        if (errors <= MAX_SHOWN) begin
            $display("ERROR: %s", msg);
        end
    endtask

    function automatic void set_relay(int u, logic on);
        run_cnt[u] = '0;
        relay[u]   = on;
    endfunction

    function automatic logic may_start(int u);
        return !relay[u] && (32'(run_cnt[u]) > 32'(cfg_now.min_off));
    endfunction

    function automatic logic may_stop(int u);
        return relay[u] && (32'(run_cnt[u]) > 32'(cfg_now.min_on));
    endfunction

    function automatic void stage_units();
        int               mid;
        int               top;
        int               n;
        logic [CNT_W-1:0] a;
        logic [CNT_W-1:0] b;
        logic [CNT_W-1:0] c;
        a = run_cnt[0];
        b = run_cnt[1];
        c = run_cnt[2];
        // last in the order has the largest elapsed count and is preferred first
        if (a < b) begin
            if (b < c) begin
                mid = 1; top = 2;
            end else if (a < c) begin
                mid = 2; top = 1;
            end else begin
                mid = 0; top = 1;
            end
        end else begin
            if (a < c) begin
                mid = 0; top = 2;
            end else if (c < b) begin
                mid = 1; top = 0;
            end else begin
                mid = 2; top = 0;
            end
        end
        for (int u = 0; u < NUM_UNITS; u++) begin
            if (relay[u] && (32'(run_cnt[u]) > 32'(cfg_now.max_run))) begin
                set_relay(u, 1'b0);
            end
        end
        n = $countones(relay);
        if (hum_now >= cfg_now.hum_three) begin
            for (int u = 0; u < NUM_UNITS; u++) begin
                if (may_start(u)) set_relay(u, 1'b1);
            end
        end else if (hum_now >= cfg_now.hum_two) begin
            if (n == 0) begin
                if (may_start(top)) set_relay(top, 1'b1);
                if (may_start(mid)) set_relay(mid, 1'b1);
            end else if (n == 1) begin
                if (may_start(top)) set_relay(top, 1'b1);
                else if (may_start(mid)) set_relay(mid, 1'b1);
            end else if (n == 3) begin
                if (may_stop(top)) set_relay(top, 1'b0);
            end
        end else if (hum_now >= cfg_now.hum_one) begin
            if (n == 0) begin
                if (may_start(top)) set_relay(top, 1'b1);
            end else if (n == 2) begin
                if (may_stop(top)) set_relay(top, 1'b0);
                else if (may_stop(mid)) set_relay(mid, 1'b0);
            end else if (n == 3) begin
                if (may_stop(top)) set_relay(top, 1'b0);
                if (may_stop(mid)) set_relay(mid, 1'b0);
            end
        end else begin
            for (int u = 0; u < NUM_UNITS; u++) begin
                if (may_stop(u)) set_relay(u, 1'b0);
            end
        end
    endfunction

    function automatic t_status dehum_step(t_item it);
        t_status st;
        case (it.action)
            ACT_TICK: begin
                for (int u = 0; u < NUM_UNITS; u++) begin
                    if (run_cnt[u] != CNT_TOP) run_cnt[u]++;
                end
            end
            ACT_SET_HUM: begin
                hum_now = it.humidity;
            end
            ACT_TOGGLE_UNIT: begin
                if (it.unit_select != UNIT_SEL_NONE) begin
                    auto_on = 1'b0;
                    set_relay(int'(it.unit_select), !relay[it.unit_select]);
                end
            end
            ACT_TOGGLE_AUTO: begin
                auto_on = !auto_on;
            end
            ACT_TOGGLE_POWER: begin
                pwr_on = !pwr_on;
            end
            ACT_EVAL: begin
                if (auto_on) stage_units();
            end
            default: begin
            end
        endcase
        st.unit_on   = relay;
        st.power_on  = pwr_on;
        st.auto_mode = auto_on;
        return st;
    endfunction

    function automatic void queue_cmd(logic [2:0] act, logic [6:0] hum, logic [1:0] sel);
        t_item it;
        it.action      = act;
        it.humidity    = hum;
        it.unit_select = sel;
        cmd_q.push_back(it);
        if (act == ACT_TOGGLE_AUTO) begin
            plan_auto = !plan_auto;
        end else if (act == ACT_TOGGLE_UNIT && sel != UNIT_SEL_NONE) begin
            plan_auto = 1'b0;
        end
    endfunction

    task automatic apb_xfer(input logic wr, input t_reg_idx idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic cfg_check(t_reg_idx idx);
        logic [31:0] rd;
        logic [31:0] want;
        apb_xfer(1'b0, idx, '0, rd);
        case (idx)
            REG_MAX_RUN:   want = 32'(cfg_now.max_run);
            REG_MIN_OFF:   want = 32'(cfg_now.min_off);
            REG_MIN_ON:    want = 32'(cfg_now.min_on);
            REG_HUM_ONE:   want = 32'(cfg_now.hum_one);
            REG_HUM_TWO:   want = 32'(cfg_now.hum_two);
            REG_HUM_THREE: want = 32'(cfg_now.hum_three);
            default:       want = '0;
        endcase
        if (rd !== want) begin
            report_bad($sformatf("register %s read %h want %h", idx.name(), rd, want));
        end
    endtask

    task automatic cfg_set(t_reg_idx idx, logic [31:0] val);
        logic [31:0] rd;
        logic [31:0] full;
        full = val;
        // junk above the field width must be dropped
        if (idx >= REG_HUM_ONE) full[31:7] = 25'($urandom);
        else full[31:16] = 16'($urandom);
        apb_xfer(1'b1, idx, full, rd);
        case (idx)
            REG_MAX_RUN:   cfg_now.max_run   = full[15:0];
            REG_MIN_OFF:   cfg_now.min_off   = full[15:0];
            REG_MIN_ON:    cfg_now.min_on    = full[15:0];
            REG_HUM_ONE:   cfg_now.hum_one   = full[6:0];
            REG_HUM_TWO:   cfg_now.hum_two   = full[6:0];
            REG_HUM_THREE: cfg_now.hum_three = full[6:0];
            default: begin
            end
        endcase
        cfg_check(idx);
    endtask

    task automatic wait_idle();
        do @(negedge i_clk); while (cmd_q.size() != 0 || cmd_if.valid || status_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : drive_cmd
        t_item it;
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else if (!cmd_if.valid || cmd_if.ready) begin
            if (cmd_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                it = cmd_q.pop_front();
                cmd_if.valid       <= 1'b1;
                cmd_if.action      <= it.action;
                cmd_if.humidity    <= it.humidity;
                cmd_if.unit_select <= it.unit_select;
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : watch_status
        t_item    it;
        t_pending p;
        t_status  got;
        logic     moved;
        int       f;
        moved = 1'b0;
        stat_if.ready <= ($urandom_range(99) >= snk_stall_pct);
        if (i_rst_n) begin
            if (cmd_if.valid && cmd_if.ready) begin
                it.action      = cmd_if.action;
                it.humidity    = cmd_if.humidity;
                it.unit_select = cmd_if.unit_select;
                p.st  = dehum_step(it);
                p.seq = seq_in++;
                status_q.push_back(p);
                moved = 1'b1;
            end
            if (stat_if.valid && stat_if.ready) begin
                moved = 1'b1;
                got.unit_on   = {stat_if.dryer_c_on, stat_if.dryer_b_on, stat_if.dryer_a_on};
                got.power_on  = stat_if.system_power_on;
                got.auto_mode = stat_if.auto_mode;
                if (status_q.size() == 0) begin
                    report_bad("status word with nothing pending");
                end else begin
                    p = status_q.pop_front();
                    for (f = 0; f < 5; f++) begin
                        if (got[f] !== p.st[f]) begin
                            report_bad($sformatf("word %0d %s got %b want %b",
                                                 p.seq, field_name[f], got[f], p.st[f]));
                        end
                    end
                end
            end
            quiet = moved ? 0 : quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("tb_staged_dehumidifier_rotation NOT OK");
                $finish;
            end
        end
    end

    initial begin : run_test
        logic [31:0] vals [6];
        logic [2:0]  act;
        int          k;
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        cmd_if.valid       = 1'b0;
        cmd_if.action      = ACT_TICK;
        cmd_if.humidity    = '0;
        cmd_if.unit_select = '0;
        stat_if.ready      = 1'b0;
        errors             = 0;
        quiet              = 0;
        seq_in             = 0;
        plan_auto          = 1'b1;
        src_idle_pct       = 0;
        snk_stall_pct      = 0;
        cfg_now.max_run    = MAX_RUN_RST;
        cfg_now.min_off    = MIN_OFF_RST;
        cfg_now.min_on     = MIN_ON_RST;
        cfg_now.hum_one    = HUM_ONE_RST;
        cfg_now.hum_two    = HUM_TWO_RST;
        cfg_now.hum_three  = HUM_THREE_RST;
        for (int u = 0; u < NUM_UNITS; u++) begin
            run_cnt[u] = CNT_W'(MIN_OFF_RST);
        end
        relay   = '0;
        pwr_on  = 1'b0;
        auto_on = 1'b1;
        hum_now = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < 6; i++) begin
            cfg_check(t_reg_idx'(i));
        end

        // directed pass on reset limits
        queue_cmd(ACT_TICK, 7'd127, UNIT_SEL_NONE);
        queue_cmd(ACT_TOGGLE_POWER, 7'd0, UNIT_A);
        queue_cmd(ACT_SET_HUM, 7'd127, UNIT_B);
        queue_cmd(ACT_EVAL, 7'd0, UNIT_C);
        queue_cmd(ACT_TOGGLE_UNIT, 7'd5, UNIT_SEL_NONE);
        queue_cmd(ACT_SPARE_LO, 7'd127, UNIT_A);
        queue_cmd(ACT_SPARE_HI, 7'd64, UNIT_SEL_NONE);
        queue_cmd(ACT_SET_HUM, 7'd0, UNIT_A);
        queue_cmd(ACT_EVAL, 7'd127, UNIT_A);
        queue_cmd(ACT_TOGGLE_UNIT, 7'd0, UNIT_A);
        queue_cmd(ACT_EVAL, 7'd0, UNIT_A);
        queue_cmd(ACT_TOGGLE_AUTO, 7'd0, UNIT_A);
        queue_cmd(ACT_TOGGLE_UNIT, 7'd0, UNIT_B);
        queue_cmd(ACT_TOGGLE_UNIT, 7'd0, UNIT_C);
        queue_cmd(ACT_TOGGLE_AUTO, 7'd0, UNIT_A);
        queue_cmd(ACT_SET_HUM, 7'd100, UNIT_A);
        queue_cmd(ACT_EVAL, 7'd0, UNIT_A);
        queue_cmd(ACT_SET_HUM, 7'd65, UNIT_C);
        queue_cmd(ACT_TOGGLE_POWER, 7'd0, UNIT_A);
        queue_cmd(ACT_EVAL, 7'd0, UNIT_B);
        queue_cmd(ACT_SET_HUM, 7'd55, UNIT_A);
        queue_cmd(ACT_EVAL, 7'd0, UNIT_A);
        queue_cmd(ACT_TICK, 7'd42, UNIT_B);
        queue_cmd(ACT_SET_HUM, 7'd49, UNIT_A);
        queue_cmd(ACT_EVAL, 7'd0, UNIT_C);
        wait_idle();

        // long run with units held on, then a run limit below the counts
        cfg_set(REG_MIN_OFF, 32'd0);
        cfg_set(REG_MAX_RUN, 32'hFFFF);
        queue_cmd(ACT_TICK, 7'd0, UNIT_A);
        queue_cmd(ACT_SET_HUM, 7'd127, UNIT_A);
        if (!plan_auto) queue_cmd(ACT_TOGGLE_AUTO, 7'd0, UNIT_A);
        queue_cmd(ACT_EVAL, 7'd0, UNIT_A);
        for (int i = 0; i < LONG_TICKS; i++) begin
            queue_cmd(ACT_TICK, 7'($urandom), 2'($urandom));
        end
        queue_cmd(ACT_EVAL, 7'd0, UNIT_A);
        wait_idle();
        cfg_set(REG_MAX_RUN, 32'd80);
        queue_cmd(ACT_EVAL, 7'd0, UNIT_A);
        queue_cmd(ACT_TICK, 7'd0, UNIT_A);
        queue_cmd(ACT_EVAL, 7'd0, UNIT_A);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 50; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 50; end
                default: begin src_idle_pct = 36; snk_stall_pct = 36; end
            endcase
            for (int half = 0; half < 2; half++) begin
                k = ph * 2 + half;
                wait_idle();
                if (k == 0) begin
                    vals = '{default: 32'd0};
                end else if (k == 5) begin
                    vals = '{32'hFFFF, 32'hFFFF, 32'hFFFF, 32'd127, 32'd127, 32'd127};
                end else begin
                    vals[0] = $urandom_range(0, 60);
                    vals[1] = $urandom_range(0, 20);
                    vals[2] = $urandom_range(0, 25);
                    vals[3] = $urandom_range(0, 110);
                    vals[4] = $urandom_range(0, 110);
                    vals[5] = $urandom_range(0, 110);
                end
                for (int i = 0; i < 6; i++) begin
                    cfg_set(t_reg_idx'(i), vals[i]);
                end
                for (int n = 0; n < RAND_PER_SET; n++) begin
                    k = $urandom_range(99);
                    if (!plan_auto && $urandom_range(2) == 0) act = ACT_TOGGLE_AUTO;
                    else if (k < 34) act = ACT_TICK;
                    else if (k < 58) act = ACT_EVAL;
                    else if (k < 72) act = ACT_SET_HUM;
                    else if (k < 82) act = ACT_TOGGLE_UNIT;
                    else if (k < 87) act = ACT_TOGGLE_AUTO;
                    else if (k < 94) act = ACT_TOGGLE_POWER;
                    else if (k < 97) act = ACT_SPARE_LO;
                    else act = ACT_SPARE_HI;
                    if (act == ACT_TICK) begin
                        repeat ($urandom_range(1, 4)) begin
                            queue_cmd(ACT_TICK, 7'($urandom), 2'($urandom));
                        end
                    end else begin
                        queue_cmd(act,
                                  ($urandom_range(3) == 0) ? 7'($urandom_range(127))
                                                           : 7'($urandom_range(100)),
                                  2'($urandom_range(3)));
                    end
                end
            end
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (status_q.size() != 0) begin
            report_bad($sformatf("%0d status words never arrived", status_q.size()));
        end
        if (errors == 0) begin
            $display("tb_staged_dehumidifier_rotation OK");
        end else begin
            $display("tb_staged_dehumidifier_rotation NOT OK");
        end
        $finish;
    end

endmodule

// ===== staged_dehumidifier_rotation.f =====
hw/rtl/dhr_pkg.sv
hw/rtl/dhr_in_if.sv
hw/rtl/dhr_out_if.sv
hw/rtl/dhr_regs.sv
hw/rtl/dhr_core.sv
hw/rtl/staged_dehumidifier_rotation.sv
dv/tb_staged_dehumidifier_rotation.sv
